@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ hw/rtl/shtv_pkg.sv @@
// package for the save header table validator: payload types, constants, crc step
// no dependencies
package shtv_pkg;
    localparam logic [31:0] MAX_TABLE_BYTES   = 32'd1048576;
    localparam logic [31:0] MAX_FIELD_BYTES   = 32'd65536;
    localparam logic [31:0] MAX_CONTENT_BYTES = 32'd268435456;
    localparam logic [31:0] CRC_POLY          = 32'hEDB88320;

    localparam logic [2:0] PH_HEADER     = 3'd0;
    localparam logic [2:0] PH_FIELD_HEAD = 3'd1;
    localparam logic [2:0] PH_PAYLOAD    = 3'd2;
    localparam logic [2:0] PH_SPENT      = 3'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_SAVE = 2'd1;
    localparam logic [1:0] ST_VERSION = 2'd2;
    localparam logic [1:0] ST_CORRUPT = 2'd3;

    localparam logic CFG_MAX_VERSION = 1'b0;
    localparam logic CFG_SIGNATURE   = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] field_id;
        logic [15:0] field_type;
        logic [16:0] field_length;
        logic [20:0] field_offset;
        logic [1:0]  status;
        logic        compressed;
        logic [28:0] stored_length;
        logic [28:0] content_length;
        logic [31:0] content_crc;
        logic        last_of_run;
    } out_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction
endpackage

@@ hw/rtl/shtv_queue.sv @@
// small queue of input beats between front and back
// depends on shtv_pkg
module shtv_queue
    import shtv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  in_item_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output in_item_t rd_data,
    output logic     empty
);
    in_item_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wp_reg, rp_reg;
    logic [QUEUE_AW:0]     cnt_reg;

    assign full    = (cnt_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{QUEUE_AW{1'b0}}, wr_en} - {{QUEUE_AW{1'b0}}, rd_en};
        end
    end
endmodule

@@ hw/rtl/shtv_front.sv @@
// front: accepts input beats into the queue that feeds the back
// depends on shtv_pkg, shtv_queue
module shtv_front
    import shtv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t in_data,
    output logic     full,
    input  logic     take,
    output in_item_t beat,
    output logic     beat_valid
);
    logic q_empty;

    shtv_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (in_data),
        .full    (full),
        .rd_en   (take && !q_empty),
        .rd_data (beat),
        .empty   (q_empty)
    );

    assign beat_valid = !q_empty;
endmodule

@@ hw/rtl/shtv_back.sv @@
// back: header capture, crc, table walk and result output register pair
// depends on shtv_pkg
module shtv_back
    import shtv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        beat_valid,
    input  in_item_t    beat,
    output logic        take,
    input  logic [15:0] max_version,
    input  logic [31:0] signature_word,
    output out_item_t   out_data,
    output logic        empty,
    input  logic        pop
);
    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] ver_reg, ver_next, flg_reg, flg_next;
    logic [31:0] tlen_reg, tlen_next, coff_reg, coff_next, slen_reg, slen_next;
    logic [31:0] clen_reg, clen_next, ccrc_reg, ccrc_next, hcrc_reg, hcrc_next;
    logic [31:0] crc_reg, crc_next;
    logic [20:0] pos_reg, pos_next;
    logic [63:0] fh_reg, fh_next;
    logic [16:0] left_reg, left_next;
    logic        done_reg, done_next;

    // two-entry result buffer
    out_item_t   r0_reg, r1_reg;
    logic [1:0]  rcnt_reg;
    out_item_t   e0, e1;
    logic [1:0]  n;

    assign take     = beat_valid && (rcnt_reg == 2'd0 || (rcnt_reg == 2'd1 && pop));
    assign empty    = (rcnt_reg == 2'd0);
    assign out_data = r0_reg;

    function automatic out_item_t verdict(input logic [1:0] st, input logic [15:0] f,
        input logic [31:0] sl, input logic [31:0] cl, input logic [31:0] cc);
        out_item_t r;
        r = '0;
        r.result_kind = 1'b1;
        r.status = st;
        if (st == ST_OK)
        begin
            r.compressed     = f[0];
            r.stored_length  = sl[28:0];
            r.content_length = cl[28:0];
            r.content_crc    = cc;
        end
        return r;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic [5:0]  i;
        logic [2:0]  j;
        logic [31:0] rem, len;
        logic [1:0]  st;
        logic        vd;
        out_item_t   v;
        b = beat.byte_value;
        phase_next = phase_reg; cnt_next = cnt_reg; ver_next = ver_reg; flg_next = flg_reg;
        tlen_next = tlen_reg; coff_next = coff_reg; slen_next = slen_reg;
        clen_next = clen_reg; ccrc_next = ccrc_reg; hcrc_next = hcrc_reg;
        crc_next = crc_reg; pos_next = pos_reg; fh_next = fh_reg; left_next = left_reg;
        done_next = done_reg;
        e0 = '0; e1 = '0; n = 2'd0; vd = 1'b0; v = '0;
        i = cnt_reg; j = cnt_reg[2:0]; st = ST_OK; rem = '0; len = '0;
        if (!done_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (i < 6'd28) crc_next = crc_byte(crc_reg, b);
                    if (i < 6'd4)
                    begin
                        if (b != signature_word[8*i[1:0] +: 8])
                        begin
                            v = verdict(ST_NOT_SAVE, flg_reg, slen_reg, clen_reg, ccrc_reg);
                            vd = 1'b1;
                        end
                    end
                    else if (i < 6'd6)  ver_next[8*i[0] +: 8] = b;
                    else if (i < 6'd8)  flg_next[8*i[0] +: 8] = b;
                    else if (i < 6'd12) tlen_next[8*i[1:0] +: 8] = b;
                    else if (i < 6'd16) coff_next[8*i[1:0] +: 8] = b;
                    else if (i < 6'd20) slen_next[8*i[1:0] +: 8] = b;
                    else if (i < 6'd24) clen_next[8*i[1:0] +: 8] = b;
                    else if (i < 6'd28) ccrc_next[8*i[1:0] +: 8] = b;
                    else                hcrc_next[8*i[1:0] +: 8] = b;
                    if (!vd)
                    begin
                        if (i >= 6'd31)
                        begin
                            if (ver_next == 16'd0 || ver_next > max_version) st = ST_VERSION;
                            else if (flg_next[15:1] != '0) st = ST_VERSION;
                            else if (tlen_next > MAX_TABLE_BYTES) st = ST_CORRUPT;
                            else if ({1'b0, coff_next} != 33'd32 + {1'b0, tlen_next})
                                st = ST_CORRUPT;
                            else if (slen_next > MAX_CONTENT_BYTES) st = ST_CORRUPT;
                            else if (clen_next > MAX_CONTENT_BYTES) st = ST_CORRUPT;
                            if (st != ST_OK)
                            begin
                                v = verdict(st, flg_next, slen_next, clen_next, ccrc_next);
                                vd = 1'b1;
                            end
                            else if (tlen_next == '0)
                            begin
                                st = (~crc_next == hcrc_next) ? ST_OK : ST_CORRUPT;
                                v = verdict(st, flg_next, slen_next, clen_next, ccrc_next);
                                vd = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_FIELD_HEAD; cnt_next = '0;
                                pos_next = '0; fh_next = '0;
                            end
                        end
                        else
                        begin
                            cnt_next = i + 6'd1;
                        end
                    end
                end
                PH_FIELD_HEAD:
                begin
                    crc_next = crc_byte(crc_reg, b);
                    if (j == 3'd0 && (tlen_reg - {11'd0, pos_reg}) < 32'd8)
                    begin
                        v = verdict(ST_CORRUPT, flg_reg, slen_reg, clen_reg, ccrc_reg);
                        vd = 1'b1;
                    end
                    else
                    begin
                        fh_next[8*j +: 8] = b;
                        pos_next = pos_reg + 21'd1;
                        cnt_next = {3'd0, j} + 6'd1;
                        if (j == 3'd7)
                        begin
                            len = fh_next[63:32];
                            rem = tlen_reg - {11'd0, pos_next};
                            if (len > MAX_FIELD_BYTES || len > rem)
                            begin
                                v = verdict(ST_CORRUPT, flg_reg, slen_reg, clen_reg, ccrc_reg);
                                vd = 1'b1;
                            end
                            else
                            begin
                                e0.field_id     = fh_next[15:0];
                                e0.field_type   = fh_next[31:16];
                                e0.field_length = len[16:0];
                                e0.field_offset = pos_next;
                                n = 2'd1;
                                cnt_next = '0; fh_next = '0;
                                if (len == '0)
                                begin
                                    if ({11'd0, pos_next} == tlen_reg)
                                    begin
                                        st = (~crc_next == hcrc_reg) ? ST_OK : ST_CORRUPT;
                                        v = verdict(st, flg_reg, slen_reg, clen_reg, ccrc_reg);
                                        vd = 1'b1;
                                    end
                                end
                                else
                                begin
                                    left_next = len[16:0];
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next = crc_byte(crc_reg, b);
                    pos_next = pos_reg + 21'd1;
                    if (left_reg != '0) left_next = left_reg - 17'd1;
                    if (left_next == '0)
                    begin
                        if ({11'd0, pos_next} >= tlen_reg)
                        begin
                            st = (~crc_next == hcrc_reg) ? ST_OK : ST_CORRUPT;
                            v = verdict(st, flg_reg, slen_reg, clen_reg, ccrc_reg);
                            vd = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FIELD_HEAD;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (beat.end_of_input && !vd)
            begin
                st = (phase_next == PH_HEADER && cnt_next < 6'd4) ? ST_NOT_SAVE : ST_CORRUPT;
                v = verdict(st, flg_reg, slen_reg, clen_reg, ccrc_reg);
                vd = 1'b1;
            end
            if (vd)
            begin
                done_next = 1'b1;
                phase_next = PH_SPENT;
                if (n == 2'd1) e1 = v;
                else e0 = v;
                n = n + 2'd1;
            end
            if (n == 2'd1) e0.last_of_run = 1'b1;
            if (n == 2'd2) e1.last_of_run = 1'b1;
        end
        if (beat.end_of_input)
        begin
            phase_next = PH_HEADER; cnt_next = '0; ver_next = '0; flg_next = '0;
            tlen_next = '0; coff_next = '0; slen_next = '0; clen_next = '0;
            ccrc_next = '0; hcrc_next = '0; crc_next = '1; pos_next = '0;
            fh_next = '0; left_next = '0; done_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && n == 2'd2)
        begin
            r0_reg <= e0;
            r1_reg <= e1;
        end
        else if (take && n == 2'd1)
        begin
            r0_reg <= e0;
        end
        else if (pop && rcnt_reg == 2'd2)
        begin
            r0_reg <= r1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= '0;
            phase_reg <= PH_HEADER; cnt_reg <= '0; ver_reg <= '0; flg_reg <= '0;
            tlen_reg <= '0; coff_reg <= '0; slen_reg <= '0; clen_reg <= '0;
            ccrc_reg <= '0; hcrc_reg <= '0; crc_reg <= '1; pos_reg <= '0;
            fh_reg <= '0; left_reg <= '0; done_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                rcnt_reg <= n;
                phase_reg <= phase_next; cnt_reg <= cnt_next; ver_reg <= ver_next;
                flg_reg <= flg_next; tlen_reg <= tlen_next; coff_reg <= coff_next;
                slen_reg <= slen_next; clen_reg <= clen_next; ccrc_reg <= ccrc_next;
                hcrc_reg <= hcrc_next; crc_reg <= crc_next; pos_reg <= pos_next;
                fh_reg <= fh_next; left_reg <= left_next; done_reg <= done_next;
            end
            else if (pop && !empty)
            begin
                rcnt_reg <= rcnt_reg - 2'd1;
            end
        end
    end
endmodule

@@ hw/rtl/save_header_table_validator_top.sv @@
// channel    handshake        payload
// input      push / full      in_item  (byte_value, end_of_input)
// result     pop / empty      out_item (descriptor or verdict)
// config     cfg_we           cfg_index, cfg_data
// one byte per cycle while results are popped at once; a byte with two results holds
// the next byte till its second pop; a result shows the cycle after its byte is taken
// a four-deep queue sits between input and back; back takes a beat when its buffer is
// empty or its single entry is popped; reset sets config to max_version 1, "OTSV"
// a stalled pop holds the back stage; the queue keeps accepting until full
`include "assert_macros.svh"
module save_header_table_validator_top
    import shtv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_item_t    in_item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    logic [15:0] maxv_reg;
    logic [31:0] sig_reg;
    in_item_t    beat;
    logic        beat_valid, take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxv_reg <= 16'd1;
            sig_reg  <= 32'h5653544F;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_VERSION: maxv_reg <= cfg_data[15:0];
                CFG_SIGNATURE:   sig_reg  <= cfg_data;
                default:         sig_reg  <= sig_reg;
            endcase
        end
    end

    shtv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_data    (in_item),
        .full       (full),
        .take       (take),
        .beat       (beat),
        .beat_valid (beat_valid)
    );

    shtv_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .beat_valid     (beat_valid),
        .beat           (beat),
        .take           (take),
        .max_version    (maxv_reg),
        .signature_word (sig_reg),
        .out_data       (out_item),
        .empty          (empty),
        .pop            (pop)
    );

    `ASSERT_IMPLY(a_take_valid, clk, rst_n, take, beat_valid)
    `ASSERT_IMPLY(a_kind_status, clk, rst_n, !empty && !out_item.result_kind, out_item.status == ST_OK)
    `ASSERT_NEXT(a_cfg_maxv, clk, rst_n, cfg_we && cfg_index == CFG_MAX_VERSION, maxv_reg == $past(cfg_data[15:0]))
endmodule

@@ tb/save_header_table_validator_checker.sv @@
// checker for the save header table validator: watches the input and result queues,
// predicts every descriptor and verdict and compares each popped result with the whole prediction
// depends on shtv_pkg
module save_header_table_validator_checker
    import shtv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  in_item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t out_item,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [31:0] cfg_data,
    output int        fail_count,
    output int        pending,
    output int        verdict_seen,
    output int        descriptor_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    out_item_t results_due[$];

    logic [15:0] lim_version;
    logic [31:0] sig_word;
    logic [2:0]  phase;
    logic [5:0]  byte_cnt;
    logic [15:0] version_r;
    logic [15:0] flags_r;
    logic [31:0] table_len;
    logic [31:0] content_off;
    logic [31:0] stored_len;
    logic [31:0] content_len;
    logic [31:0] content_crc_r;
    logic [31:0] hdr_crc;
    logic [31:0] crc_acc;
    logic [20:0] table_pos;
    logic [63:0] head_shift;
    logic [16:0] bytes_left;
    logic        done;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return r;
    endfunction

    task automatic start_file();
        phase = PH_HEADER;
        byte_cnt = 0;
        version_r = 0;
        flags_r = 0;
        table_len = 0;
        content_off = 0;
        stored_len = 0;
        content_len = 0;
        content_crc_r = 0;
        hdr_crc = 0;
        crc_acc = '1;
        table_pos = 0;
        head_shift = 0;
        bytes_left = 0;
        done = 0;
    endtask

    task automatic add_verdict(input logic [1:0] st, inout out_item_t run[$]);
        out_item_t r;
        r = '0;
        r.result_kind = 1'b1;
        r.status = st;
        if (st == ST_OK)
        begin
            r.compressed = flags_r[0];
            r.stored_length = stored_len[28:0];
            r.content_length = content_len[28:0];
            r.content_crc = content_crc_r;
        end
        run = {run, r};
        done = 1;
        phase = PH_SPENT;
    endtask

    function automatic logic [1:0] header_verdict();
        if (version_r == 0 || version_r > lim_version) return ST_VERSION;
        if (flags_r[15:1] != 0) return ST_VERSION;
        if (table_len > MAX_TABLE_BYTES) return ST_CORRUPT;
        if ({1'b0, content_off} != 33'd32 + {1'b0, table_len}) return ST_CORRUPT;
        if (stored_len > MAX_CONTENT_BYTES) return ST_CORRUPT;
        if (content_len > MAX_CONTENT_BYTES) return ST_CORRUPT;
        return ST_OK;
    endfunction

    function automatic logic [1:0] crc_verdict();
        return (~crc_acc == hdr_crc) ? ST_OK : ST_CORRUPT;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic eoi);
        out_item_t run[$];
        int i;
        logic [63:0] len;
        logic [1:0] st;
        if (!done)
        begin
            if (phase == PH_HEADER)
            begin
                i = byte_cnt;
                if (i < 28) crc_acc = crc_step(crc_acc, b);
                if (i < 4)
                begin
                    if (b != sig_word[8*i +: 8]) add_verdict(ST_NOT_SAVE, run);
                end
                else if (i < 6) version_r[8*(i-4) +: 8] = b;
                else if (i < 8) flags_r[8*(i-6) +: 8] = b;
                else if (i < 12) table_len[8*(i-8) +: 8] = b;
                else if (i < 16) content_off[8*(i-12) +: 8] = b;
                else if (i < 20) stored_len[8*(i-16) +: 8] = b;
                else if (i < 24) content_len[8*(i-20) +: 8] = b;
                else if (i < 28) content_crc_r[8*(i-24) +: 8] = b;
                else hdr_crc[8*(i-28) +: 8] = b;
                if (!done)
                begin
                    if (i >= 31)
                    begin
                        st = header_verdict();
                        if (st != ST_OK) add_verdict(st, run);
                        else if (table_len == 0) add_verdict(crc_verdict(), run);
                        else
                        begin
                            phase = PH_FIELD_HEAD;
                            byte_cnt = 0;
                            table_pos = 0;
                            head_shift = 0;
                        end
                    end
                    else byte_cnt = 6'(i + 1);
                end
            end
            else if (phase == PH_FIELD_HEAD)
            begin
                i = byte_cnt[2:0];
                crc_acc = crc_step(crc_acc, b);
                if (i == 0 && table_len - {11'd0, table_pos} < 32'd8)
                    add_verdict(ST_CORRUPT, run);
                else
                begin
                    head_shift[8*i +: 8] = b;
                    table_pos++;
                    byte_cnt = 6'(i + 1);
                    if (byte_cnt == 8)
                    begin
                        len = {32'd0, head_shift[63:32]};
                        if (len > MAX_FIELD_BYTES || len > {32'd0, table_len - table_pos})
                            add_verdict(ST_CORRUPT, run);
                        else
                        begin
                            out_item_t d;
                            d = '0;
                            d.field_id = head_shift[15:0];
                            d.field_type = head_shift[31:16];
                            d.field_length = len[16:0];
                            d.field_offset = table_pos;
                            run = {run, d};
                            byte_cnt = 0;
                            head_shift = 0;
                            if (len == 0)
                            begin
                                if ({11'd0, table_pos} == table_len)
                                    add_verdict(crc_verdict(), run);
                            end
                            else
                            begin
                                bytes_left = len[16:0];
                                phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
            end
            else if (phase == PH_PAYLOAD)
            begin
                crc_acc = crc_step(crc_acc, b);
                table_pos++;
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0)
                begin
                    if ({11'd0, table_pos} >= table_len) add_verdict(crc_verdict(), run);
                    else phase = PH_FIELD_HEAD;
                end
            end
            if (eoi && !done)
                add_verdict((phase == PH_HEADER && byte_cnt < 4) ? ST_NOT_SAVE : ST_CORRUPT, run);
        end
        if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
        results_due = {results_due, run};
        if (eoi) start_file();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_version = 16'd1;
            sig_word = 32'h5653544F;
            start_file();
            results_due.delete();
            fail_count = 0;
            verdict_seen = 0;
            descriptor_seen = 0;
        end
        else
        begin
            if (!empty && pop)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected beat %p", $time, out_item);
                    fail_count++;
                end
                else
                begin
                    out_item_t e;
                    e = results_due.pop_front();
                    if (e !== out_item)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
                        fail_count++;
                    end
                    if (out_item.result_kind) verdict_seen++;
                    else descriptor_seen++;
                end
            end
            if (push && !full) predict_byte(in_item.byte_value, in_item.end_of_input);
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_VERSION) lim_version = cfg_data[15:0];
                else sig_word = cfg_data;
            end
        end
        pending = results_due.size();
    end
endmodule

@@ tb/save_header_table_validator_top_test.sv @@
// testbench top for the save header table validator: builds save files, drives
// the byte queue and configuration port, stalls both sides and gives the verdict
// depends on shtv_pkg, save_header_table_validator_top and the checker
module save_header_table_validator_top_test
    import shtv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        push;
    in_item_t    in_item;
    logic        full;
    logic        empty;
    logic        pop;
    out_item_t   out_item;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          verdict_seen;
    int          descriptor_seen;
    int          bytes_sent;
    int          push_idle;
    int          pop_idle;
    longint      cycle_count;
    logic [15:0] cur_max_version;
    logic [31:0] cur_signature;
    logic [7:0]  file_bytes[$];

    save_header_table_validator_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .in_item(in_item), .full(full),
        .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    save_header_table_validator_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
        .pending(pending), .verdict_seen(verdict_seen),
        .descriptor_seen(descriptor_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= pop_idle);
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return r;
    endfunction

    task automatic put32(input logic [31:0] v);
        for (int k = 0; k < 4; k++) file_bytes = {file_bytes, v[8*k +: 8]};
    endtask

    // builds a well-formed file, then optionally breaks it
    task automatic build_file(input int nfields, input int maxlen, input int flaw);
        logic [7:0]  tbl[$];
        logic [31:0] crc;
        logic [31:0] tlen;
        logic [15:0] ver;
        int len;
        file_bytes.delete();
        for (int f = 0; f < nfields; f++)
        begin
            len = $urandom_range(maxlen);
            for (int k = 0; k < 4; k++) tbl = {tbl, 8'($urandom_range(255))};
            for (int k = 0; k < 4; k++)
                tbl = {tbl, (k == 0 ? len[7:0] : (k == 1 ? len[15:8] : 8'd0))};
            for (int k = 0; k < len; k++) tbl = {tbl, 8'($urandom_range(255))};
        end
        tlen = 32'(tbl.size());
        ver = 16'($urandom_range(cur_max_version == 0 ? 1 : cur_max_version, 1));
        put32(cur_signature);
        file_bytes = {file_bytes, ver[7:0]};
        file_bytes = {file_bytes, ver[15:8]};
        file_bytes = {file_bytes, 8'($urandom_range(1))};
        file_bytes = {file_bytes, 8'd0};
        put32(tlen);
        put32(tlen + 32'd32);
        put32($urandom_range(32'h10000000));
        put32($urandom_range(32'h10000000));
        put32($urandom());
        crc = '1;
        foreach (file_bytes[k]) crc = crc_step(crc, file_bytes[k]);
        foreach (tbl[k]) crc = crc_step(crc, tbl[k]);
        put32(~crc);
        foreach (tbl[k]) file_bytes = {file_bytes, tbl[k]};
        if (flaw == 1) file_bytes[$urandom_range(file_bytes.size()-1)] ^= 8'd1 << $urandom_range(7);
        else if (flaw == 2) file_bytes[$urandom_range(file_bytes.size()-1)] = 8'($urandom_range(255));
        else if (flaw == 3) file_bytes = file_bytes[0:$urandom_range(file_bytes.size()-1)];
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < push_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{byte_value: b, end_of_input: eoi};
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[k]) send_byte(file_bytes[k], k == file_bytes.size() - 1);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_MAX_VERSION) cur_max_version = v[15:0];
        else cur_signature = v;
    endtask

    task automatic random_files(input int count);
        int flaw;
        for (int n = 0; n < count; n++)
        begin
            flaw = $urandom_range(9);
            flaw = flaw < 6 ? 0 : flaw - 6;
            build_file($urandom_range(3), $urandom_range(1) ? 6 : 20, flaw);
            if ($urandom_range(9) == 0)
                for (int k = 0; k < 4; k++) send_byte(8'($urandom_range(255)), 1'b0);
            send_file();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAX_VERSION;
        cfg_data = '0;
        cycle_count = 0;
        bytes_sent = 0;
        push_idle = 35;
        pop_idle = 63;
        cur_max_version = 16'd1;
        cur_signature = 32'h5653544F;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, fields, signature miss, short ends, bad headers
        build_file(0, 0, 0);
        send_file();
        build_file(2, 3, 0);
        send_file();
        send_byte(8'h00, 1'b1);
        send_byte(8'h4F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        build_file(1, 2, 0);
        file_bytes[4] = 8'h02;
        send_file();
        build_file(1, 2, 0);
        file_bytes[7] = 8'h80;
        send_file();
        build_file(0, 0, 0);
        file_bytes[11] = 8'hFF;
        send_file();
        build_file(1, 0, 3);
        send_file();
        drain();

        write_cfg(CFG_MAX_VERSION, 32'h0000FFFF);
        write_cfg(CFG_SIGNATURE, 32'hFFFFFFFF);
        random_files(4);
        drain();
        write_cfg(CFG_SIGNATURE, 32'h00000000);
        write_cfg(CFG_MAX_VERSION, 32'h0);
        random_files(2);
        drain();
        write_cfg(CFG_MAX_VERSION, 32'd7);
        write_cfg(CFG_SIGNATURE, $urandom());
        push_idle = 63;
        pop_idle = 35;
        random_files(3);
        drain();
        write_cfg(CFG_SIGNATURE, 32'h5653544F);
        push_idle = 0;
        pop_idle = 0;
        random_files(3);
        drain();

        $display("sent %0d bytes, checked %0d descriptors and %0d verdicts",
                 bytes_sent, descriptor_seen, verdict_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
